// ===== rtl/core/dmm_lcd_pkg.sv =====
// Types, constants and segment decode shared by the multimeter LCD frame decoder.
`default_nettype none

package dmm_lcd_pkg;

  localparam int unsigned FrameBytes = 14;
  localparam int unsigned NibDepth   = FrameBytes - 2;
  localparam int unsigned CountW     = 4;
  localparam int unsigned MantW      = 15;
  localparam int unsigned ExpW       = 4;
  localparam int unsigned UnitW      = 2;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned MagW       = 14;

  localparam logic [CountW-1:0] CountMax = 4'd15;
  localparam logic [3:0]        HiStart  = 4'h1;
  localparam logic [3:0]        HiEnd    = 4'hE;

  typedef enum logic [UnitW-1:0] {
    UnitUnknown = 2'd0,
    UnitVolt    = 2'd1,
    UnitAmp     = 2'd2
  } unit_e;

  typedef struct packed {
    logic value_changed;
    logic frame_ok;
  } res_flags_t;

  // Map segment pattern to a digit; unknown patterns read as zero
  function automatic logic [DigitW-1:0] seg_digit(logic [2:0] a, logic [3:0] b);
    logic [DigitW-1:0] d;
    case ({a, b})
      {3'h7, 4'hD}: d = 4'd0;
      {3'h0, 4'h5}: d = 4'd1;
      {3'h5, 4'hB}: d = 4'd2;
      {3'h1, 4'hF}: d = 4'd3;
      {3'h2, 4'h7}: d = 4'd4;
      {3'h3, 4'hE}: d = 4'd5;
      {3'h7, 4'hE}: d = 4'd6;
      {3'h1, 4'h5}: d = 4'd7;
      {3'h7, 4'hF}: d = 4'd8;
      {3'h3, 4'hF}: d = 4'd9;
      default:      d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dmm_lcd_frame_decoder.sv =====
// Multimeter LCD frame decoder: serial bytes in, decoded readings out.
`default_nettype none

// Takes one serial byte per word on the slave side and emits one reading word on
// the master side for every end byte (high nibble E); other bytes give no word.
// A byte with high nibble 1 restarts the byte count. An end byte that closes a
// fourteen-byte frame yields the signed four-digit mantissa, the decimal exponent,
// the unit and a change flag against the last reported (mantissa, exponent) pair;
// any other end byte yields an all-zero reading with frame_ok low. Each byte goes
// through one input register and one result register, so a word can be taken
// every cycle unless an end byte is held up; an end byte waits in the input
// register only while the result register still holds an untaken reading.
module dmm_lcd_frame_decoder
  import dmm_lcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // [14:0] reading_mantissa, [18:15] decimal_exponent,
                                           // [20:19] unit_code, [23:21] zero
  output      res_flags_t  m_axis_tuser    // [0] frame_ok, [1] value_changed
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic [CountW-1:0] count_q, count_d;
  logic [3:0]        nib_q [NibDepth];

  logic                    out_valid_q, out_valid_d;
  logic signed [MantW-1:0] out_mant_q;
  logic [ExpW-1:0]         out_exp_q;
  unit_e                   out_unit_q;
  res_flags_t              out_flags_q;

  logic signed [MantW-1:0] last_mant_q;
  logic [ExpW-1:0]         last_exp_q;

  logic [3:0]        hi, lo;
  logic              is_end, out_free, advance, s_fire;
  logic [CountW-1:0] pos, wr_idx;
  logic              nib_we, frame_good, changed;
  logic [DigitW-1:0] dig [4];
  logic [MagW-1:0]   mag;
  logic signed [MantW-1:0] mant;
  logic [ExpW-1:0]   expo;
  unit_e             unit;

  assign hi       = in_byte_q[7:4];
  assign lo       = in_byte_q[3:0];
  assign is_end   = (hi == HiEnd);
  assign out_free = !out_valid_q || m_axis_tready;
  assign advance  = in_valid_q && (!is_end || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire   = s_axis_tvalid && s_axis_tready;

  assign pos     = (hi == HiStart) ? '0 : count_q;
  assign count_d = (pos == CountMax) ? CountMax : pos + 4'd1;
  assign wr_idx  = pos - 4'd1;
  assign nib_we  = advance && (pos >= 4'd1) && (pos <= CountW'(NibDepth));
  assign frame_good = (count_d == CountW'(FrameBytes));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dig[k] = seg_digit(nib_q[2*k][2:0], nib_q[2*k+1]);
    end
  end

  assign mag = ({10'd0, dig[0]} * 14'd1000) + ({10'd0, dig[1]} * 14'd100)
             + ({10'd0, dig[2]} * 14'd10) + {10'd0, dig[3]};
  assign mant = nib_q[0][3] ? $signed(15'd0 - {1'b0, mag}) : $signed({1'b0, mag});

  assign expo = (nib_q[2][3] ? 4'd3 : 4'd0) + (nib_q[4][3] ? 4'd2 : 4'd0)
              + (nib_q[6][3] ? 4'd1 : 4'd0) + (nib_q[9][3] ? 4'd3 : 4'd0)
              + (nib_q[8][3] ? 4'd3 : 4'd0);

  always_comb begin
    if (nib_q[11][3]) begin
      unit = UnitAmp;
    end else if (nib_q[11][2]) begin
      unit = UnitVolt;
    end else begin
      unit = UnitUnknown;
    end
  end

  assign changed = frame_good && ((mant != last_mant_q) || (expo != last_exp_q));

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && is_end) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      last_mant_q <= '1;
      last_exp_q  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        count_q <= count_d;
      end
      if (advance && is_end && changed) begin
        last_mant_q <= mant;
        last_exp_q  <= expo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
    end
    if (nib_we) begin
      nib_q[wr_idx] <= lo;
    end
    if (advance && is_end) begin
      out_mant_q                <= frame_good ? mant : '0;
      out_exp_q                 <= frame_good ? expo : '0;
      out_unit_q                <= frame_good ? unit : UnitUnknown;
      out_flags_q.frame_ok      <= frame_good;
      out_flags_q.value_changed <= changed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_unit_q, out_exp_q, out_mant_q};
  assign m_axis_tuser  = out_flags_q;

`ifndef NO_ASSERTIONS
  a_bad_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_flags_q.frame_ok |->
      (out_mant_q == '0) && (out_exp_q == '0) && !out_flags_q.value_changed)
    else $error("bad frame reading not zero");

  a_last_pair_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_flags_q.value_changed |->
      (last_mant_q == out_mant_q) && (last_exp_q == out_exp_q))
    else $error("last pair differs from reported change");

  a_mant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_mant_q <= 15'sd9999) && (out_mant_q >= -15'sd9999))
    else $error("mantissa out of range");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (count_q == CountMax) && (hi != HiStart) |=> (count_q == CountMax))
    else $error("byte count left saturation");
`endif

endmodule

`default_nettype wire

// ===== test/dmm_lcd_frame_decoder_test.sv =====
// Self-checking testbench for the multimeter LCD frame decoder: directed and random byte streams.
`default_nettype none

module dmm_lcd_frame_decoder_test;
  import dmm_lcd_pkg::*;

  localparam int LongHold    = 300;
  localparam int StallLimit  = 3000;
  localparam int DrainWait   = 10;
  localparam int PrintCap    = 40;
  localparam int RandomBytes = 440;
  localparam int ExpLo       = MantW;
  localparam int UnitLo      = MantW + ExpW;

  typedef struct packed {
    logic [MantW-1:0] mant;
    logic [ExpW-1:0]  expo;
    unit_e            unit;
    logic             frame_ok;
    logic             changed;
  } reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [14:0] reading_mantissa, [18:15] decimal_exponent,
                               // [20:19] unit_code, [23:21] zero
  res_flags_t  m_axis_tuser;   // [0] frame_ok, [1] value_changed

  dmm_lcd_frame_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  logic [3:0]        nib_store [1:NibDepth];
  logic [CountW-1:0] frame_count;
  logic [MantW-1:0]  shown_mant;
  logic [ExpW-1:0]   shown_expo;
  reading_t          expected_readings [$];

  int          error_cnt;
  int          bytes_sent;
  int          words_seen;
  int          bad_frames;
  int          unchanged_readings;
  int          idle_cycles;
  bit          bursts_on;
  bit          long_hold_req;
  bit          frame_sent;
  logic [47:0] last_nibs;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [6:0] segment_pattern(int unsigned digit);
    logic [6:0] seg;
    case (digit)
      0:       seg = 7'h7D;
      1:       seg = 7'h05;
      2:       seg = 7'h5B;
      3:       seg = 7'h1F;
      4:       seg = 7'h27;
      5:       seg = 7'h3E;
      6:       seg = 7'h7E;
      7:       seg = 7'h15;
      8:       seg = 7'h7F;
      9:       seg = 7'h3F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

  function automatic int unsigned decode_digit(logic [6:0] seg);
    for (int d = 0; d <= 9; d++) begin
      if (segment_pattern(d) == seg) return d;
    end
    return 0;
  endfunction

  function automatic int flag_bit(int p, int b);
    return (p - 1) * 4 + b;
  endfunction

  // Digits above nine keep whatever segment bits the base holds
  function automatic logic [47:0] place_digits(logic [47:0] nibs, logic [15:0] digits);
    logic [3:0] dval;
    logic [6:0] seg;
    for (int k = 0; k < 4; k++) begin
      dval = digits[(3 - k) * 4 +: 4];
      if (dval <= 9) begin
        seg = segment_pattern(32'(dval));
        nibs[(2 * k) * 4 +: 3]     = seg[6:4];
        nibs[(2 * k + 1) * 4 +: 4] = seg[3:0];
      end
    end
    return nibs;
  endfunction

  function automatic logic [7:0] rand_mid_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b[7:4] == HiStart || b[7:4] == HiEnd) b = 8'($urandom);
    return b;
  endfunction

  function automatic void predict_byte(logic [7:0] rx);
    reading_t    r;
    int unsigned mag;
    r = '0;
    r.unit = UnitUnknown;
    if (rx[7:4] == HiStart) frame_count = '0;
    if (frame_count >= 1 && frame_count <= NibDepth) nib_store[frame_count] = rx[3:0];
    if (frame_count != CountMax) frame_count = frame_count + 1'b1;
    if (rx[7:4] != HiEnd) return;
    if (frame_count == FrameBytes) begin
      mag = 0;
      for (int k = 0; k < 4; k++) begin
        mag = mag * 10 + decode_digit({nib_store[2 * k + 1][2:0], nib_store[2 * k + 2]});
      end
      r.mant = MantW'(mag);
      if (nib_store[1][3]) r.mant = -r.mant;
      r.expo = ExpW'(3 * nib_store[3][3] + 2 * nib_store[5][3] + nib_store[7][3]
                     + 3 * nib_store[10][3] + 3 * nib_store[9][3]);
      if (nib_store[12][3]) r.unit = UnitAmp;
      else if (nib_store[12][2]) r.unit = UnitVolt;
      r.frame_ok = 1'b1;
      r.changed  = (r.mant != shown_mant) || (r.expo != shown_expo);
      if (r.changed) begin
        shown_mant = r.mant;
        shown_expo = r.expo;
      end else begin
        unchanged_readings++;
      end
    end else begin
      bad_frames++;
    end
    expected_readings.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_cnt++;
    if (error_cnt <= PrintCap)
      $display("word %0d: %s got %0d, want %0d", words_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata);
  end

  always @(posedge clk_i) begin : check_word
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        want = expected_readings.pop_front();
        if (m_axis_tdata[MantW-1:0] !== want.mant)
          report_mismatch("mantissa", int'($signed(m_axis_tdata[MantW-1:0])),
                          int'($signed(want.mant)));
        if (m_axis_tdata[ExpLo +: ExpW] !== want.expo)
          report_mismatch("exponent", int'(m_axis_tdata[ExpLo +: ExpW]), int'(want.expo));
        if (m_axis_tdata[UnitLo +: UnitW] !== want.unit)
          report_mismatch("unit", int'(m_axis_tdata[UnitLo +: UnitW]), int'(want.unit));
        if (m_axis_tuser.frame_ok !== want.frame_ok)
          report_mismatch("frame_ok", int'(m_axis_tuser.frame_ok), int'(want.frame_ok));
        if (m_axis_tuser.value_changed !== want.changed)
          report_mismatch("value_changed", int'(m_axis_tuser.value_changed),
                          int'(want.changed));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("no word moved for %0d cycles", StallLimit);
      $display("dmm_lcd_frame_decoder: mismatch");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] rx);
    int gap;
    gap = 0;
    if (bursts_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [47:0] nibs, input logic [7:0] first_byte,
                            input logic [7:0] last_byte);
    logic [3:0] pos_code;
    send_byte(first_byte);
    for (int p = 1; p <= NibDepth; p++) begin
      pos_code = 4'(p + 1);
      send_byte({pos_code, nibs[(p - 1) * 4 +: 4]});
    end
    send_byte(last_byte);
  endtask

  task automatic send_random_frame();
    logic [47:0] nibs;
    logic [15:0] digits;
    logic [3:0]  start_lo;
    logic [3:0]  end_lo;
    if (frame_sent && $urandom_range(0, 3) == 0) begin
      nibs = last_nibs;
    end else begin
      for (int k = 0; k < 4; k++) begin
        digits[k * 4 +: 4] = 4'($urandom_range(0, 9));
        if ($urandom_range(0, 9) == 0) digits[k * 4 +: 4] = 4'hF;
      end
      nibs = place_digits(48'({$urandom, $urandom}), digits);
    end
    last_nibs  = nibs;
    frame_sent = 1'b1;
    start_lo   = 4'($urandom);
    end_lo     = 4'($urandom);
    send_frame(nibs, {HiStart, start_lo}, {HiEnd, end_lo});
  endtask

  task automatic send_broken_frame(input int mid_bytes);
    logic [3:0] start_lo;
    logic [3:0] end_lo;
    start_lo = 4'($urandom);
    end_lo   = 4'($urandom);
    send_byte({HiStart, start_lo});
    repeat (mid_bytes) send_byte(rand_mid_byte());
    send_byte({HiEnd, end_lo});
  endtask

  // Count from reset with no start byte: all flags, amps, largest negative reading
  task automatic test_frame_from_reset();
    logic [47:0] nibs;
    nibs = place_digits('0, 16'h9999);
    nibs[flag_bit(1, 3)]  = 1'b1;
    nibs[flag_bit(3, 3)]  = 1'b1;
    nibs[flag_bit(5, 3)]  = 1'b1;
    nibs[flag_bit(7, 3)]  = 1'b1;
    nibs[flag_bit(9, 3)]  = 1'b1;
    nibs[flag_bit(10, 3)] = 1'b1;
    nibs[flag_bit(12, 3)] = 1'b1;
    nibs[flag_bit(12, 2)] = 1'b1;
    send_frame(nibs, 8'h00, {HiEnd, 4'h0});
  endtask

  task automatic test_short_frame();
    send_byte({HiStart, 4'hF});
    send_byte(8'h2A);
    send_byte({HiEnd, 4'h0});
  endtask

  // Zero with an unknown digit, then the same digits with the sign set and the volt flag cleared
  task automatic test_negative_zero();
    logic [47:0] nibs;
    nibs = place_digits('0, 16'h0F00);
    nibs[flag_bit(12, 2)] = 1'b1;
    send_frame(nibs, {HiStart, 4'h0}, {HiEnd, 4'hF});
    nibs[flag_bit(12, 2)] = 1'b0;
    nibs[flag_bit(1, 3)]  = 1'b1;
    send_frame(nibs, {HiStart, 4'hF}, {HiEnd, 4'h0});
  endtask

  // End byte straight after an end byte gives a bad-length reading and takes the count to saturation
  task automatic test_end_after_end();
    send_byte({HiEnd, 4'h5});
  endtask

  task automatic test_random_stream();
    int pick;
    while (bytes_sent < RandomBytes) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) send_random_frame();
      else if (pick == 7) send_broken_frame($urandom_range(0, 11));
      else if (pick == 8) send_broken_frame($urandom_range(13, 16));
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end
  endtask

  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    repeat (4) send_random_frame();
  endtask

  task automatic test_unthrottled_tail();
    bursts_on = 1'b0;
    repeat (3) send_random_frame();
    send_broken_frame($urandom_range(0, 11));
  endtask

  initial begin
    rst_ni             = 1'b0;
    s_axis_tvalid      = 1'b0;
    s_axis_tdata       = '0;
    bursts_on          = 1'b1;
    long_hold_req      = 1'b0;
    frame_sent         = 1'b0;
    last_nibs          = '0;
    error_cnt          = 0;
    bytes_sent         = 0;
    words_seen         = 0;
    bad_frames         = 0;
    unchanged_readings = 0;
    idle_cycles        = 0;
    frame_count        = '0;
    shown_mant         = '1;
    shown_expo         = '0;
    for (int p = 1; p <= NibDepth; p++) nib_store[p] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_frame_from_reset();
    test_short_frame();
    test_negative_zero();
    test_end_after_end();
    test_random_stream();
    test_output_backpressure();
    test_unthrottled_tail();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    $display("sent %0d bytes, checked %0d readings (%0d bad-length frames, %0d unchanged)",
             bytes_sent, words_seen, bad_frames, unchanged_readings);
    $display("covered reset count, negative zero, saturation, a %0d-cycle hold, no-idle tail",
             LongHold);
    if (error_cnt == 0) $display("dmm_lcd_frame_decoder: match");
    else $display("dmm_lcd_frame_decoder: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
